/* rtl/core/cab_pkg.sv */
package cab_pkg;

  localparam int unsigned COORD_MAX = 8192;

  localparam int unsigned BOUND_W  = 14;
  localparam int unsigned STRIDE_W = 15;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned PIX_W    = 32;
  localparam int unsigned OFFS_W   = 27;
  localparam int unsigned CIDX_W   = 3;
  localparam int unsigned CDATA_W  = 15;

  localparam int unsigned IN_TDATA_W   = 96;
  localparam int unsigned OUT_TDATA_W  = 64;
  localparam int unsigned OUT_TUSER_W  = 1;

  localparam logic [CIDX_W-1:0] REG_CLIP_LEFT     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_CLIP_TOP      = 3'd1;
  localparam logic [CIDX_W-1:0] REG_CLIP_RIGHT    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_CLIP_BOTTOM   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
  localparam logic [CIDX_W-1:0] REG_ROW_STRIDE    = 3'd6;

  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [BOUND_W-1:0]  clip_left;
    logic [BOUND_W-1:0]  clip_top;
    logic [BOUND_W-1:0]  clip_right;
    logic [BOUND_W-1:0]  clip_bottom;
    logic [BOUND_W-1:0]  screen_width;
    logic [BOUND_W-1:0]  screen_height;
    logic [STRIDE_W-1:0] row_stride;
  } cab_cfg_t;

endpackage

/* rtl/core/cab_cfg.sv */
module cab_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [cab_pkg::CIDX_W-1:0]      wr_index,
  input  logic [cab_pkg::CDATA_W-1:0]     wr_data,
  output cab_pkg::cab_cfg_t               cfg
);
  import cab_pkg::*;

  cab_cfg_t cfg_r;
  cab_cfg_t cfg_nxt;
  logic [BOUND_W-1:0] bound_sat;

  // bounds saturate to COORD_MAX at write time
  always_comb begin
    if (32'(wr_data[BOUND_W-1:0]) > COORD_MAX) begin
      bound_sat = BOUND_W'(COORD_MAX);
    end else begin
      bound_sat = wr_data[BOUND_W-1:0];
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_CLIP_LEFT:     cfg_nxt.clip_left     = bound_sat;
        REG_CLIP_TOP:      cfg_nxt.clip_top      = bound_sat;
        REG_CLIP_RIGHT:    cfg_nxt.clip_right    = bound_sat;
        REG_CLIP_BOTTOM:   cfg_nxt.clip_bottom   = bound_sat;
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width  = bound_sat;
        REG_SCREEN_HEIGHT: cfg_nxt.screen_height = bound_sat;
        REG_ROW_STRIDE:    cfg_nxt.row_stride    = wr_data[STRIDE_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/cab_clip.sv */
module cab_clip (
  input  logic signed [cab_pkg::COORD_W-1:0] pos_x,
  input  logic signed [cab_pkg::COORD_W-1:0] pos_y,
  input  cab_pkg::cab_cfg_t                  cfg,
  output logic                               keep,
  output logic [cab_pkg::OFFS_W-1:0]         word_offset
);
  import cab_pkg::*;

  logic [COORD_W-2:0]         xu;
  logic [COORD_W-2:0]         yu;
  logic [2*STRIDE_W-1:0]      prod;
  logic [OFFS_W-1:0]          offs;

  assign xu = pos_x[COORD_W-2:0];
  assign yu = pos_y[COORD_W-2:0];

  assign keep = !pos_x[COORD_W-1] && !pos_y[COORD_W-1] &&
                (xu >= (COORD_W-1)'(cfg.clip_left)) &&
                (yu >= (COORD_W-1)'(cfg.clip_top)) &&
                (xu <  (COORD_W-1)'(cfg.clip_right)) &&
                (yu <  (COORD_W-1)'(cfg.clip_bottom)) &&
                (xu <  (COORD_W-1)'(cfg.screen_width)) &&
                (yu <  (COORD_W-1)'(cfg.screen_height));

  assign prod = yu * cfg.row_stride;
  assign offs = prod[OFFS_W-1:0] + OFFS_W'(xu);

  assign word_offset = keep ? offs : '0;

endmodule

/* rtl/core/cab_blend.sv */
module cab_blend (
  input  logic [cab_pkg::PIX_W-1:0] src_argb,
  input  logic [cab_pkg::PIX_W-1:0] dest_word,
  input  logic                      keep,
  output logic [cab_pkg::PIX_W-1:0] blended_color
);
  import cab_pkg::*;

  logic [7:0]  alpha;
  logic [7:0]  alpha_inv;
  logic [23:0] mixed;

  assign alpha     = src_argb[31:24];
  assign alpha_inv = ALPHA_OPAQUE - alpha;

  // per channel: (old*(255-a) + new*a + 127) / 255
  // divide by 255 as (t + (t>>8) + 1) >> 8, exact for t < 65535
  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    logic [16:0] sum;
    logic [16:0] quo;

    assign sum = 17'(dest_word[8*ch +: 8]) * 17'(alpha_inv) +
                 17'(src_argb[8*ch +: 8]) * 17'(alpha) + 17'd127;
    assign quo = sum + 17'(sum[16:8]) + 17'd1;
    assign mixed[8*ch +: 8] = quo[15:8];
  end

  always_comb begin
    if (!keep || alpha == ALPHA_CLEAR) begin
      blended_color = dest_word;
    end else if (alpha == ALPHA_OPAQUE) begin
      blended_color = {8'h00, src_argb[23:0]};
    end else begin
      blended_color = {8'h00, mixed};
    end
  end

endmodule

/* rtl/core/clipped_argb_alpha_blend_unit.sv */
// Channel  | Dir | Transfer when          | Payload
// in_      | in  | in_tvalid & in_tready  | tdata: pos_x, pos_y, src_argb, dest_word
// out_     | out | out_tvalid & out_tready| tuser: write_enable; tdata: offset, color
// cfg_     | in  | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// One pixel per cycle sustained while out_tready stays high; the result is registered.
// Work sits between the input register and the output register: the clip
// compares, one 15x15 offset multiply and the three-lane blend.
// A stalled output holds both stages; in_tready stays high while the input
// stage is empty or moving. cfg_ready is always high.
// Synchronous active-low reset clears the stage valids and config registers.
module clipped_argb_alpha_blend_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] pos_x, [31:16] pos_y, [63:32] src_argb, [95:64] dest_word
  input  logic [cab_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [26:0] word_offset, [58:27] blended_color, [63:59] zero
  output logic [cab_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [0] write_enable
  output logic [cab_pkg::OUT_TUSER_W-1:0]     out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cab_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [cab_pkg::CDATA_W-1:0]         cfg_data
);
  import cab_pkg::*;

  cab_cfg_t cfg;

  logic                      s1_valid_r;
  logic                      s1_valid_nxt;
  logic [IN_TDATA_W-1:0]     s1_data_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [OUT_TDATA_W-1:0]    out_data_r;
  logic [OUT_TDATA_W-1:0]    out_data_nxt;
  logic [OUT_TUSER_W-1:0]    out_user_r;
  logic [OUT_TUSER_W-1:0]    out_user_nxt;

  logic                      advance;
  logic                      in_xfer;
  logic                      keep;
  logic [OFFS_W-1:0]         word_offset;
  logic [PIX_W-1:0]          blended_color;

  assign cfg_ready = 1'b1;

  cab_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cab_clip u_clip (
    .pos_x       (s1_data_r[15:0]),
    .pos_y       (s1_data_r[31:16]),
    .cfg         (cfg),
    .keep        (keep),
    .word_offset (word_offset)
  );

  cab_blend u_blend (
    .src_argb      (s1_data_r[63:32]),
    .dest_word     (s1_data_r[95:64]),
    .keep          (keep),
    .blended_color (blended_color)
  );

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      out_data_nxt  = {(OUT_TDATA_W-OFFS_W-PIX_W)'(0), blended_color, word_offset};
      out_user_nxt  = OUT_TUSER_W'(keep);
    end
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_tdata;
    end
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* rtl/core/cab_checker.sv */
module cab_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tready,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [cab_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic [cab_pkg::OUT_TUSER_W-1:0]     out_tuser
);
  import cab_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  a_drop_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[OFFS_W-1:0] == '0)
    else $error("dropped pixel with nonzero offset");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind clipped_argb_alpha_blend_unit cab_checker u_cab_checker (.*);
